FILE: hdl/spsd_pkg.sv
package spsd_pkg;

  // Opcodes of an input item.
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_POLL   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  // Configuration register file.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_FLOOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 1'b1;

  localparam logic [CFG_DATA_W-1:0] FLOOR_RESET = 16'd130;
  localparam logic [CFG_DATA_W-1:0] HOLD_RESET  = 16'd400;

  // Millisecond counter.
  localparam int unsigned TICK_W = 16;

  // Per-transfer strobes from the input side to the lanes and the merge stage.
  typedef struct packed {
    logic sample;
    logic tick;
    logic poll;
  } ctl_t;

endpackage

FILE: hdl/spsd_if.sv
interface spsd_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  spsd_pkg::opcode_e             opcode;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output opcode, output left_sample,
                  output right_sample, input ready);
  modport sink (input valid, input opcode, input left_sample,
                input right_sample, output ready);
endinterface

interface spsd_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] level;
  logic                   beam_on;
  logic                   beam_changed;

  modport source (output valid, output level, output beam_on,
                  output beam_changed, input ready);
  modport sink (input valid, input level, input beam_on,
                input beam_changed, output ready);
endinterface

FILE: hdl/spsd_lane.sv
module spsd_lane #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spsd_pkg::ctl_t                ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic        [SAMPLE_BITS-1:0] peak_o
);
  import spsd_pkg::*;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] peak_d, peak_q;

  // Magnitude of the sample; the most negative code wraps to 2^(N-1) unsigned.
  assign mag = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;

  // Running peak, cleared by a poll.
  always_comb begin
    peak_d = peak_q;
    if (ctl_i.poll) begin
      peak_d = '0;
    end else if (ctl_i.sample && (mag > peak_q)) begin
      peak_d = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else begin
      peak_q <= peak_d;
    end
  end

  assign peak_o = peak_q;

endmodule

FILE: hdl/spsd_merge.sv
module spsd_merge #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spsd_pkg::ctl_t                    ctl_i,
  input  logic [SAMPLE_BITS-1:0]            peak_left_i,
  input  logic [SAMPLE_BITS-1:0]            peak_right_i,
  input  logic [spsd_pkg::CFG_DATA_W-1:0]   floor_i,
  input  logic [spsd_pkg::CFG_DATA_W-1:0]   hold_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [SAMPLE_BITS-1:0]            level_o,
  output logic                              beam_on_o,
  output logic                              beam_changed_o
);
  import spsd_pkg::*;

  localparam int unsigned CMP_W = (SAMPLE_BITS > CFG_DATA_W) ? SAMPLE_BITS : CFG_DATA_W;

  logic [SAMPLE_BITS-1:0] level;
  logic                   hit;
  logic                   live;
  logic [TICK_W-1:0]      ticks_d, ticks_q;
  logic                   seen_d, seen_q;
  logic                   lit_d, lit_q;
  logic                   out_valid_d, out_valid_q;
  logic [SAMPLE_BITS-1:0] level_q;
  logic                   beam_q;
  logic                   chg_q;

  // Combine the lanes and judge the level against the floor.
  assign level = (peak_left_i > peak_right_i) ? peak_left_i : peak_right_i;
  assign hit   = CMP_W'(level) > CMP_W'(floor_i);
  assign live  = (seen_q || hit) && ((hit ? '0 : ticks_q) < hold_i);

  // Silence counter, signal flag and beam state.
  always_comb begin
    ticks_d = ticks_q;
    seen_d  = seen_q;
    lit_d   = lit_q;
    if (ctl_i.tick && (ticks_q != '1)) begin
      ticks_d = ticks_q + 1'b1;
    end
    if (ctl_i.poll) begin
      if (hit) begin
        ticks_d = '0;
        seen_d  = 1'b1;
      end
      lit_d = live;
    end
  end

  // Output register: loaded by a poll, emptied by an output transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.poll) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q     <= '0;
      seen_q      <= 1'b0;
      lit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ticks_q     <= ticks_d;
      seen_q      <= seen_d;
      lit_q       <= lit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.poll) begin
      level_q <= level;
      beam_q  <= live;
      chg_q   <= live ^ lit_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign level_o        = level_q;
  assign beam_on_o      = beam_q;
  assign beam_changed_o = chg_q;

`ifndef SYNTHESIS
  // A poll always leaves a result waiting.
  a_poll_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.poll |=> out_valid_q) else $error("poll gave no result");

  // A level above the floor at a poll restarts the silence count.
  a_hit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.poll && hit) |=> (ticks_q == '0) && seen_q) else $error("count not restarted");

  // The reported beam state is the one kept for the next poll.
  a_beam_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.poll |=> (lit_q == beam_q) && (chg_q == (beam_q != $past(lit_q))))
    else $error("beam state mismatch");

  // The beam cannot be lit before any signal was seen.
  a_dark_unseen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> !lit_q) else $error("beam lit without signal");
`endif

endmodule

FILE: hdl/stereo_peak_silence_detector.sv
// Stereo peak detector with silence hold.
//
// Input channel (in_if): one transfer per item. A sample item updates the
// running absolute peak of each channel, a tick item advances the saturating
// millisecond count, and a poll item reads and clears both peaks. Opcode 3 is
// dropped without effect. Only a poll returns a result on out_if: the larger
// peak as level, the beam state and whether that state changed.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 silence floor, 1 hold time in ticks); the user must write only while
// the block is idle, which the block does not enforce. Latency: a poll's
// result is valid the cycle after its transfer. Throughput: one item per
// cycle but for a waiting poll; the two channel lanes and the merge stage
// each finish their work in the cycle of the transfer. Stall: the single
// output register holds a result until it is taken. While it is full and
// out_if.ready is low, a poll waits; samples and ticks still transfer at
// full rate. Reset: peaks and count clear, no signal seen, beam dark, floor
// 130 and hold time 400.
module stereo_peak_silence_detector #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  spsd_in_if.sink                           in_if,
  spsd_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [spsd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [spsd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import spsd_pkg::*;

  ctl_t                   ctl;
  logic                   xfer;
  logic [CFG_DATA_W-1:0]  floor_q, floor_d;
  logic [CFG_DATA_W-1:0]  hold_q, hold_d;
  logic [SAMPLE_BITS-1:0] peak_left, peak_right;

  // Accept unless a poll would overwrite a result that is still waiting.
  assign in_if.ready = !out_if.valid || out_if.ready || (in_if.opcode != OP_POLL);
  assign xfer        = in_if.valid && in_if.ready;

  always_comb begin
    ctl = '0;
    case (in_if.opcode)
      OP_SAMPLE: ctl.sample = xfer;
      OP_TICK:   ctl.tick   = xfer;
      OP_POLL:   ctl.poll   = xfer;
      default:   ctl        = '0;
    endcase
  end

  // Configuration registers.
  always_comb begin
    floor_d = floor_q;
    hold_d  = hold_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SILENCE_FLOOR: floor_d = cfg_data_i;
        REG_HOLD_TICKS:    hold_d  = cfg_data_i;
        default:           floor_d = floor_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FLOOR_RESET;
      hold_q  <= HOLD_RESET;
    end else begin
      floor_q <= floor_d;
      hold_q  <= hold_d;
    end
  end

  // One peak lane per channel.
  spsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (in_if.left_sample),
    .peak_o   (peak_left)
  );

  spsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (in_if.right_sample),
    .peak_o   (peak_right)
  );

  // Merge the lanes and run the silence hold.
  spsd_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .peak_left_i    (peak_left),
    .peak_right_i   (peak_right),
    .floor_i        (floor_q),
    .hold_i         (hold_q),
    .out_ready_i    (out_if.ready),
    .out_valid_o    (out_if.valid),
    .level_o        (out_if.level),
    .beam_on_o      (out_if.beam_on),
    .beam_changed_o (out_if.beam_changed)
  );

endmodule
